// File: src/rqs_pkg.sv
`timescale 1ns / 1ps
package rqs_pkg;
   localparam int NCPU = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int QW = $clog2(NCPU);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int OW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = QW + PW;

   localparam logic [2:0] ST_ENQUEUED = 3'd0;
   localparam logic [2:0] ST_LOCAL = 3'd1;
   localparam logic [2:0] ST_STOLEN = 3'd2;
   localparam logic [2:0] ST_EMPTY = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_SCAN,
      S_ACT,
      S_READ,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic scan_step;
      logic act;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic scan_done;
      logic is_pick;
   } stat_type;
endpackage

// File: src/rqs_ctrl.sv
`timescale 1ns / 1ps
module rqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rqs_pkg::stat_type stat,
   output rqs_pkg::cmd_type  cmd
);
   rqs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rqs_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         rqs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rqs_pkg::S_MOD;
            end
         end
         rqs_pkg::S_MOD: begin
            // Enqueue reduces affinity; pick scans occupancy.
            if (stat.is_pick) state_in = rqs_pkg::S_SCAN;
            else begin
               cmd.mod_step = 1'b1;
               if (stat.mod_done) state_in = rqs_pkg::S_ACT;
            end
         end
         rqs_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = rqs_pkg::S_ACT;
         end
         rqs_pkg::S_ACT: begin
            cmd.act = 1'b1;
            state_in = rqs_pkg::S_READ;
         end
         rqs_pkg::S_READ: begin
            cmd.capture = 1'b1;
            state_in = rqs_pkg::S_OUT;
         end
         rqs_pkg::S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = rqs_pkg::S_IDLE;
         end
         default: state_in = rqs_pkg::S_IDLE;
      endcase
   end
endmodule

// File: src/rqs_dp.sv
`timescale 1ns / 1ps
module rqs_dp (
   input  logic              clock,
   input  logic              reset,
   input  rqs_pkg::cmd_type  cmd,
   output rqs_pkg::stat_type stat,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata,
   input  logic              req_cmd,
   input  logic [2:0]        req_requester,
   input  logic [7:0]        req_task_id,
   input  logic [31:0]       req_affinity,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_task_out,
   output logic [2:0]        rsp_queue_used
);
   localparam int QWX = rqs_pkg::QW + 1;
   localparam int MW = 32 + QWX;

   logic [3:0] cpu_count_ff;
   logic [QWX-1:0] n_act;
   logic pick_ff;
   logic [2:0] requester_ff;
   logic [7:0] task_ff;
   logic [31:0] rem_ff;
   logic [MW-1:0] dsh_ff;
   logic [5:0] bit_ff;
   logic [rqs_pkg::QW-1:0] scan_ff, best_ff, q_ff;
   logic [rqs_pkg::OW-1:0] most_ff;
   logic [2:0] status_ff;
   logic found_ff;
   logic [rqs_pkg::PW-1:0] head_ff [rqs_pkg::NCPU];
   logic [rqs_pkg::PW-1:0] tail_ff [rqs_pkg::NCPU];
   logic [rqs_pkg::OW-1:0] occ_ff [rqs_pkg::NCPU];
   logic [7:0] mem [rqs_pkg::NCPU*rqs_pkg::QUEUE_DEPTH];
   logic [7:0] rd_ff;
   logic [2:0] st_o_ff, q_o_ff;
   logic [7:0] t_o_ff;
   logic local_ok;

   always_comb begin
      if (cpu_count_ff == 4'd0) n_act = QWX'(1);
      else if (32'(cpu_count_ff) > rqs_pkg::NCPU) n_act = QWX'(rqs_pkg::NCPU);
      else n_act = QWX'(cpu_count_ff);
   end

   assign local_ok = (32'(requester_ff) < rqs_pkg::NCPU) &&
                     (occ_ff[requester_ff[rqs_pkg::QW-1:0]] != '0);
   assign stat.is_pick = pick_ff;
   assign stat.mod_done = (bit_ff == 6'd0);
   assign stat.scan_done = local_ok || (32'(scan_ff) + 1 >= 32'(n_act));

   always_ff @(posedge clock) begin
      if (reset) cpu_count_ff <= 4'd8;
      else if (csr_we) cpu_count_ff <= csr_wdata;
   end

   // Restoring division, one quotient bit a cycle, remainder only.
   always_ff @(posedge clock) begin
      logic [MW-1:0] t;
      if (cmd.load) begin
         pick_ff <= req_cmd;
         requester_ff <= req_requester;
         task_ff <= req_task_id;
         rem_ff <= req_affinity;
         dsh_ff <= MW'(n_act) << 31;
         bit_ff <= 6'd31;
         scan_ff <= '0;
         best_ff <= '0;
         most_ff <= '0;
      end
      if (cmd.mod_step) begin
         t = MW'(rem_ff);
         if (t >= dsh_ff) rem_ff <= 32'(t - dsh_ff);
         dsh_ff <= dsh_ff >> 1;
         if (bit_ff != 6'd0) bit_ff <= bit_ff - 6'd1;
      end
      if (cmd.scan_step && !local_ok) begin
         if (occ_ff[scan_ff] > most_ff) begin
            most_ff <= occ_ff[scan_ff];
            best_ff <= scan_ff;
         end
         scan_ff <= scan_ff + 1'b1;
      end
   end

   // Select the target queue and the outcome for the access cycle.
   logic [rqs_pkg::QW-1:0] tq;
   logic [2:0] tst;
   always_comb begin
      tq = rem_ff[rqs_pkg::QW-1:0];
      tst = rqs_pkg::ST_ENQUEUED;
      if (!pick_ff) begin
         if (32'(occ_ff[tq]) >= rqs_pkg::QUEUE_DEPTH) tst = rqs_pkg::ST_FULL;
      end else if (local_ok) begin
         tq = requester_ff[rqs_pkg::QW-1:0];
         tst = rqs_pkg::ST_LOCAL;
      end else if (most_ff == '0) begin
         tq = '0;
         tst = rqs_pkg::ST_EMPTY;
      end else begin
         tq = best_ff;
         tst = rqs_pkg::ST_STOLEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rqs_pkg::NCPU; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            occ_ff[i] <= '0;
         end
      end else if (cmd.act) begin
         if (tst == rqs_pkg::ST_ENQUEUED) begin
            tail_ff[tq] <= (32'(tail_ff[tq]) + 1 >= rqs_pkg::QUEUE_DEPTH) ?
                           '0 : tail_ff[tq] + 1'b1;
            occ_ff[tq] <= occ_ff[tq] + 1'b1;
         end else if (tst == rqs_pkg::ST_LOCAL || tst == rqs_pkg::ST_STOLEN) begin
            head_ff[tq] <= (32'(head_ff[tq]) + 1 >= rqs_pkg::QUEUE_DEPTH) ?
                           '0 : head_ff[tq] + 1'b1;
            occ_ff[tq] <= occ_ff[tq] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.act) begin
         q_ff <= tq;
         status_ff <= tst;
         found_ff <= (tst == rqs_pkg::ST_LOCAL || tst == rqs_pkg::ST_STOLEN);
         if (tst == rqs_pkg::ST_ENQUEUED)
            mem[{tq, tail_ff[tq]}] <= task_ff;
         rd_ff <= mem[{tq, head_ff[tq]}];
      end
      if (cmd.capture) begin
         st_o_ff <= status_ff;
         q_o_ff <= 3'(q_ff);
         t_o_ff <= found_ff ? rd_ff :
                   (status_ff == rqs_pkg::ST_EMPTY ? 8'd0 : task_ff);
      end
   end

   assign rsp_status = st_o_ff;
   assign rsp_task_out = t_o_ff;
   assign rsp_queue_used = q_o_ff;
endmodule

// File: src/per_cpu_run_queue_with_stealing.sv
`timescale 1ns / 1ps
// Per-processor run queues with work stealing. Requests are handled one at a
// time: an enqueue runs the bit-serial remainder unit that reduces the
// 32-bit affinity modulo the active processor count; a pick runs the
// one-queue-per-cycle scan for the busiest queue (the scan stops as soon
// as the requester's own queue has a task). The result register holds
// the response until taken. cpu_count may only be written while idle.
module per_cpu_run_queue_with_stealing (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_cpu_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [2:0]  req_requester,
   input  logic [7:0]  req_task_id,
   input  logic [31:0] req_affinity,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_task_out,
   output logic [2:0]  rsp_queue_used
);
   rqs_pkg::cmd_type  cmd;
   rqs_pkg::stat_type stat;

   // The controller sequences each request; the datapath holds the queues.
   rqs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd)
   );

   rqs_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .csr_we(csr_we), .csr_wdata(csr_cpu_count),
      .req_cmd(req_cmd), .req_requester(req_requester),
      .req_task_id(req_task_id), .req_affinity(req_affinity),
      .rsp_status(rsp_status), .rsp_task_out(rsp_task_out),
      .rsp_queue_used(rsp_queue_used)
   );
endmodule

// File: src/rqs_checker.sv
`timescale 1ns / 1ps
module rqs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_task_out,
   input logic [2:0] rsp_queue_used
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_legal_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= rqs_pkg::ST_FULL) else $error("bad status");
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rqs_pkg::ST_EMPTY) |-> (rsp_task_out == 8'd0 &&
      rsp_queue_used == 3'd0)) else $error("empty result not zero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_task_out))
      else $error("response dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("double accept");
endmodule

bind per_cpu_run_queue_with_stealing rqs_checker u_rqs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_task_out(rsp_task_out), .rsp_queue_used(rsp_queue_used)
);
